[src/uccf_pkg.sv]
// Package: constants, result type and set-membership functions for the character class block.
package uccf_pkg;

    localparam int CP_W    = 21;
    localparam int RADIX_W = 6;
    localparam int CFG_IDX_W = 2;

    typedef logic [CP_W-1:0] cp_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX   = 2'd0,
        CFG_STD     = 2'd1,
        CFG_VISIBLE = 2'd2,
        CFG_UNUSED  = 2'd3
    } cfg_idx_t;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    typedef struct packed {
        logic lower_ascii;
        logic upper_ascii;
        logic greek;
        logic greek_lc;
        logic greek_uc;
        logic ext_range;
        logic ext_letter;
        logic ext_lc;
        logic ext_uc;
        logic ipa;
        logic whitespace;
        logic digit;
    } flags_t;

    function automatic logic in_greek_lower(input cp_t cp);
        logic hit;
        case (cp) inside
            21'h0371, 21'h0373, 21'h0377, 21'h037B, 21'h037C, 21'h037D, 21'h0390,
            [21'h03AC:21'h03CE],
            21'h03D9, 21'h03DB, 21'h03DD, 21'h03DF, 21'h03E1, 21'h03E3, 21'h03E5,
            21'h03E7, 21'h03E9, 21'h03EB, 21'h03ED, 21'h03EF: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic in_greek_upper(input cp_t cp);
        logic hit;
        case (cp) inside
            21'h0370, 21'h0372, 21'h0376, 21'h037F, 21'h0386, 21'h0388, 21'h0389,
            21'h038A, 21'h038C, 21'h038E, 21'h038F,
            [21'h0391:21'h03AB],
            21'h03CF, 21'h03D8, 21'h03DA, 21'h03DC, 21'h03DE, 21'h03E0, 21'h03E2,
            21'h03E4, 21'h03E6, 21'h03E8, 21'h03EA, 21'h03EC, 21'h03EE, 21'h03F7,
            21'h03F9, 21'h03FA, 21'h03FD, 21'h03FE, 21'h03FF: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic in_ipa_extra(input cp_t cp);
        logic hit;
        case (cp) inside
            21'h0020, 21'h0028, 21'h0029, 21'h002F, 21'h003C, 21'h003D, 21'h005F,
            21'h007B, 21'h007C, 21'h007D, 21'h00E6, 21'h00F0, 21'h00F8, 21'h0127,
            21'h014B, 21'h0153, 21'h01C0, 21'h01C1, 21'h01C2, 21'h01C3, 21'h0221,
            21'h0234, 21'h0235, 21'h0236, 21'h03B2, 21'h03B8, 21'h03C7, 21'h0593,
            21'h0594, 21'h0595, 21'h0599, 21'h0600: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic in_ext_lower(input cp_t cp);
        logic hit;
        case (cp) inside
            [21'h00E0:21'h00F6], [21'h00F8:21'h00FF],
            21'h0101, 21'h0103, 21'h0105, 21'h0107, 21'h0109, 21'h010B, 21'h010D,
            21'h010F, 21'h0111, 21'h0113, 21'h0115, 21'h0117, 21'h0119, 21'h011B,
            21'h011D, 21'h011F, 21'h0121, 21'h0123, 21'h0125, 21'h0127, 21'h0129,
            21'h012B, 21'h012D, 21'h012F, 21'h0131, 21'h0133, 21'h0135, 21'h0137,
            21'h0138, 21'h013A, 21'h013C, 21'h013E, 21'h0140, 21'h0142, 21'h0144,
            21'h0146, 21'h0148, 21'h0149, 21'h014B, 21'h014D, 21'h014F, 21'h0151,
            21'h0153, 21'h0155, 21'h0157, 21'h0159, 21'h015B, 21'h015D, 21'h015F,
            21'h0161, 21'h0163, 21'h0165, 21'h0167, 21'h0169, 21'h016B, 21'h016D,
            21'h016F, 21'h0171, 21'h0173, 21'h0175, 21'h0177, 21'h017A, 21'h017C,
            21'h017E, 21'h017F, 21'h0180, 21'h0183, 21'h0185, 21'h0188, 21'h018C,
            21'h018D, 21'h0192, 21'h0195, 21'h0199, 21'h019A, 21'h019B, 21'h019E,
            21'h01A1, 21'h01A3, 21'h01A5, 21'h01A8, 21'h01AB, 21'h01AD, 21'h01B0,
            21'h01B4, 21'h01B6, 21'h01B9, 21'h01BA, 21'h01BD, 21'h01C6, 21'h01C9,
            21'h01CC, 21'h01CE, 21'h01D0, 21'h01D2, 21'h01D4, 21'h01D6, 21'h01D8,
            21'h01DA, 21'h01DC, 21'h01DD, 21'h01DF, 21'h01E1, 21'h01E3, 21'h01E5,
            21'h01E7, 21'h01E9, 21'h01EB, 21'h01ED, 21'h01EF, 21'h01F3, 21'h01F5,
            21'h01F7, 21'h01F9, 21'h01FB, 21'h01FD, 21'h01FF, 21'h0201, 21'h0203,
            21'h0205, 21'h0207, 21'h0209, 21'h020B, 21'h020D, 21'h020F, 21'h0211,
            21'h0213, 21'h0215, 21'h0217, 21'h0219, 21'h021B, 21'h021D, 21'h021F,
            21'h0221, 21'h0223, 21'h0225, 21'h0227, 21'h0229, 21'h022B, 21'h022D,
            21'h022F, 21'h0231, 21'h0233, 21'h0234, 21'h0235, 21'h0236, 21'h0237,
            21'h0238, 21'h0239, 21'h023C, 21'h023F, 21'h0240, 21'h0242, 21'h0247,
            21'h0249, 21'h024B, 21'h024D, 21'h024F: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Plain and line-break whitespace together.
    function automatic logic in_ws(input cp_t cp);
        logic hit;
        case (cp) inside
            21'h0009, 21'h0020, 21'h00A0, 21'h1680, [21'h2000:21'h200D], 21'h202F,
            21'h205F, 21'h3000, 21'h180E, 21'h2060, 21'hFEFF,
            [21'h000A:21'h000D], 21'h0085, 21'h2028, 21'h2029: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic in_ws_visible(input cp_t cp);
        logic hit;
        case (cp) inside
            21'h00B7, 21'h237D, 21'h2420, 21'h2422, 21'h2423, 21'h2800: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic in_duodec(input cp_t cp);
        logic hit;
        case (cp) inside
            21'h0041, 21'h0042, 21'h0045, 21'h0054, 21'h0058, 21'h2130, 21'h218A,
            21'h218B, 21'h1D4B3: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

[src/unicode_char_class_flags_top.sv]
// Top level: registered Unicode character classifier with configuration port.

// Each accepted code point is classified into twelve flags and delivered through
// two registers: first the input register, then the result register.
// A new code point is taken every cycle; s_ready drops only while both registers
// are full and the downstream side does not take the result. The radix and
// the two include options are written through the cfg port, which always
// accepts (cfg_ready is held high); index 3 is ignored. Write them only while
// no transfer is in flight. Reset values: radix 10, include_standard 1,
// include_visible 0.
module unicode_char_class_flags_top
    import uccf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CP_W-1:0]      s_code_point,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_latin_lower,
    output logic                 m_is_latin_upper,
    output logic                 m_is_greek,
    output logic                 m_is_greek_lower,
    output logic                 m_is_greek_upper,
    output logic                 m_is_latin_ext,
    output logic                 m_is_latin_ext_letter,
    output logic                 m_is_latin_ext_lower,
    output logic                 m_is_latin_ext_upper,
    output logic                 m_is_ipa,
    output logic                 m_is_whitespace,
    output logic                 m_is_digit,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RADIX_W-1:0]   cfg_data
);

    logic [RADIX_W-1:0] radix_reg;
    logic               std_reg;
    logic               visible_reg;

    logic               in_valid_reg, in_valid_next;
    cp_t                cp_reg;
    logic               out_valid_reg, out_valid_next;
    flags_t             flags_reg, flags_next;
    logic               advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg   <= RADIX_RESET;
            std_reg     <= 1'b1;
            visible_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RADIX:   radix_reg   <= cfg_data;
                CFG_STD:     std_reg     <= cfg_data[0];
                CFG_VISIBLE: visible_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The result register frees up when it is empty or being taken.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cp_reg <= s_code_point;
        end
        if (advance && in_valid_reg) begin
            flags_reg <= flags_next;
        end
    end

    // Classification of the registered code point.
    logic               lo, uc, gr, ext, ext_let, ext_tab, dec;
    cp_t                up;
    cp_t                radix_ext;

    always_comb begin
        lo      = (cp_reg >= 21'h61) && (cp_reg <= 21'h7A);
        uc      = (cp_reg >= 21'h41) && (cp_reg <= 21'h5A);
        gr      = (cp_reg >= 21'h370) && (cp_reg <= 21'h3FF);
        ext     = (cp_reg >= 21'hC0) && (cp_reg <= 21'h24F);
        ext_let = ext && (cp_reg != 21'hD7) && (cp_reg != 21'hF7);
        ext_tab = ext_let && in_ext_lower(cp_reg);
        dec     = (cp_reg >= 21'h30) && (cp_reg <= 21'h39);
        up      = lo ? (cp_reg - 21'h20) : cp_reg;
        radix_ext = {{(CP_W-RADIX_W){1'b0}}, radix_reg};

        flags_next.lower_ascii = lo;
        flags_next.upper_ascii = uc;
        flags_next.greek       = gr;
        flags_next.greek_lc    = gr && in_greek_lower(cp_reg);
        flags_next.greek_uc    = gr && in_greek_upper(cp_reg);
        flags_next.ext_range   = ext;
        flags_next.ext_letter  = ext_let;
        flags_next.ext_lc      = (std_reg && lo) || ext_tab;
        flags_next.ext_uc      = (std_reg && uc) || (ext_let && !ext_tab);
        flags_next.ipa = lo
            || ((cp_reg >= 21'h250) && (cp_reg <= 21'h36F))
            || ((cp_reg >= 21'h1D00) && (cp_reg <= 21'h1DBF))
            || ((cp_reg >= 21'h2070) && (cp_reg <= 21'h209F))
            || ((cp_reg >= 21'hA700) && (cp_reg <= 21'hA71F))
            || in_ipa_extra(cp_reg);
        flags_next.whitespace = in_ws(cp_reg) || (visible_reg && in_ws_visible(cp_reg));

        // Radix 2 to 10 takes leading decimal digits; 12 adds the duodecimal letters
        // and symbols; 11 and 13 to 35 extend with folded ASCII letters; others match none.
        if ((radix_reg >= 6'd2) && (radix_reg <= 6'd10)) begin
            flags_next.digit = (cp_reg >= 21'h30) && (cp_reg <= 21'h2F + radix_ext);
        end else if (radix_reg == 6'd12) begin
            flags_next.digit = dec || in_duodec(up);
        end else if ((radix_reg >= 6'd11) && (radix_reg <= 6'd35)) begin
            flags_next.digit = dec || ((up >= 21'h41) && (up <= 21'h36 + radix_ext));
        end else begin
            flags_next.digit = 1'b0;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_is_latin_lower      = flags_reg.lower_ascii;
    assign m_is_latin_upper      = flags_reg.upper_ascii;
    assign m_is_greek            = flags_reg.greek;
    assign m_is_greek_lower      = flags_reg.greek_lc;
    assign m_is_greek_upper      = flags_reg.greek_uc;
    assign m_is_latin_ext        = flags_reg.ext_range;
    assign m_is_latin_ext_letter = flags_reg.ext_letter;
    assign m_is_latin_ext_lower  = flags_reg.ext_lc;
    assign m_is_latin_ext_upper  = flags_reg.ext_uc;
    assign m_is_ipa              = flags_reg.ipa;
    assign m_is_whitespace       = flags_reg.whitespace;
    assign m_is_digit            = flags_reg.digit;

endmodule
